/* hw/rtl/bounded_deque_engine_defines.svh */
// Assertion macros shared by the deque RTL.
`ifndef BOUNDED_DEQUE_ENGINE_DEFINES_SVH
`define BOUNDED_DEQUE_ENGINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BDE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// Check that cons holds in the cycle after ante.
`define BDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

/* hw/rtl/bde_pkg.sv */
package bde_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned COUNT_OUT_W = 5;

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_POP_FRONT  = 3'd1,
		MODE_PUSH_FRONT = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK       = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

endpackage

/* hw/rtl/bounded_deque_engine.sv */
// Pushes, peeks and refusals register their result directly when the request is transferred;
// a pop that leaves the queue non-empty first passes through ST_FETCH (one word-store read for the new end).
// The word store has a single read port; no new request is taken while in ST_FETCH.
// A new request is taken while the previous result is being transferred.
// Reset (arst_n low, asynchronous): queue empty, head at slot 0, no result pending.
// The word store itself is not cleared; only occupied slots are ever read.
`include "bounded_deque_engine_defines.svh"

module bounded_deque_engine #(
	parameter int unsigned DEPTH = bde_pkg::DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [2:0]          mode,
	input  logic signed [31:0]  value_in,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic signed [31:0]  value_out,
	output logic [1:0]          status,
	output logic [4:0]          entry_count,
	output logic                is_empty,
	output logic signed [31:0]  front_value,
	output logic signed [31:0]  back_value
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

	logic [bde_pkg::WORD_W-1:0] mem [DEPTH];
	logic [bde_pkg::WORD_W-1:0] rd_q;

	bde_pkg::state_t state_q;
	logic rsp_valid_q;
	logic [IDX_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [bde_pkg::WORD_W-1:0] front_q, back_q, value_out_q;
	bde_pkg::status_t status_q;
	logic rd_front_q;

	logic accept, full, empty, refused;
	logic [IDX_W-1:0] head_nxt, tail_nxt;
	logic [IDX_W-1:0] head_next_idx, head_prev_idx, tail_next_idx, tail_prev_idx;
	logic [CNT_W-1:0] count_nxt;
	logic [bde_pkg::WORD_W-1:0] front_nxt, back_nxt, popped;
	bde_pkg::status_t status_nxt;
	logic wr_en, rd_en, rd_front;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [CNT_W+bde_pkg::COUNT_OUT_W-1:0] count_ext;

	function automatic logic [bde_pkg::WORD_W-1:0] wr_data_sel(input logic signed [31:0] v);
		return bde_pkg::WORD_W'(unsigned'(v));
	endfunction

	assign req_stall = (state_q != bde_pkg::ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept = req_valid && !req_stall;
	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign refused = accept && (status_nxt != bde_pkg::STAT_DONE);

	assign head_next_idx = (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
	assign head_prev_idx = (head_q == '0) ? LAST_IDX : head_q - IDX_W'(1);
	assign tail_next_idx = (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
	assign tail_prev_idx = (tail_q == '0) ? LAST_IDX : tail_q - IDX_W'(1);

	always_comb begin
		head_nxt = head_q;
		tail_nxt = tail_q;
		count_nxt = count_q;
		front_nxt = front_q;
		back_nxt = back_q;
		popped = '0;
		status_nxt = bde_pkg::STAT_DONE;
		wr_en = 1'b0;
		wr_addr = tail_next_idx;
		rd_en = 1'b0;
		rd_addr = head_next_idx;
		rd_front = 1'b1;
		case (bde_pkg::mode_t'(mode))
			bde_pkg::MODE_PUSH_BACK: begin
				if (full) begin
					status_nxt = bde_pkg::STAT_FULL;
				end else begin
					tail_nxt = tail_next_idx;
					count_nxt = count_q + ONE_CNT;
					wr_en = 1'b1;
					wr_addr = tail_next_idx;
					back_nxt = value_in;
					if (empty) begin
						front_nxt = value_in;
					end
				end
			end
			bde_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					status_nxt = bde_pkg::STAT_FULL;
				end else begin
					head_nxt = head_prev_idx;
					count_nxt = count_q + ONE_CNT;
					wr_en = 1'b1;
					wr_addr = head_prev_idx;
					front_nxt = value_in;
					if (empty) begin
						back_nxt = value_in;
					end
				end
			end
			bde_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					status_nxt = bde_pkg::STAT_EMPTY;
				end else begin
					popped = front_q;
					head_nxt = head_next_idx;
					count_nxt = count_q - ONE_CNT;
					rd_en = (count_q != ONE_CNT);
					rd_addr = head_next_idx;
					rd_front = 1'b1;
				end
			end
			bde_pkg::MODE_POP_BACK: begin
				if (empty) begin
					status_nxt = bde_pkg::STAT_EMPTY;
				end else begin
					popped = back_q;
					tail_nxt = tail_prev_idx;
					count_nxt = count_q - ONE_CNT;
					rd_en = (count_q != ONE_CNT);
					rd_addr = tail_prev_idx;
					rd_front = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= wr_data_sel(value_in);
		end
		if (accept && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bde_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			head_q <= '0;
			tail_q <= LAST_IDX;
			count_q <= '0;
		end else begin
			case (state_q)
				bde_pkg::ST_IDLE: begin
					if (accept) begin
						head_q <= head_nxt;
						tail_q <= tail_nxt;
						count_q <= count_nxt;
						rsp_valid_q <= !rd_en;
						state_q <= rd_en ? bde_pkg::ST_FETCH : bde_pkg::ST_IDLE;
					end else if (rsp_valid_q && !rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				bde_pkg::ST_FETCH: begin
					rsp_valid_q <= 1'b1;
					state_q <= bde_pkg::ST_IDLE;
				end
				default: begin
					state_q <= bde_pkg::ST_IDLE;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_q <= front_nxt;
			back_q <= back_nxt;
			value_out_q <= popped;
			status_q <= status_nxt;
			rd_front_q <= rd_front;
		end else if (state_q == bde_pkg::ST_FETCH) begin
			if (rd_front_q) begin
				front_q <= rd_q;
			end else begin
				back_q <= rd_q;
			end
		end
	end

	assign count_ext = {{bde_pkg::COUNT_OUT_W{1'b0}}, count_q};
	assign rsp_valid = rsp_valid_q;
	assign value_out = value_out_q;
	assign status = status_q;
	assign entry_count = count_ext[bde_pkg::COUNT_OUT_W-1:0];
	assign is_empty = empty;
	assign front_value = empty ? '0 : front_q;
	assign back_value = empty ? '0 : back_q;

	`BDE_ASSERT_SAME(a_count_range, clk, arst_n, 1'b1, count_q <= FULL_CNT)
	`BDE_ASSERT_SAME(a_fetch_no_rsp, clk, arst_n, state_q == bde_pkg::ST_FETCH, !rsp_valid_q)
	`BDE_ASSERT_NEXT(a_fetch_entry, clk, arst_n, accept && rd_en, state_q == bde_pkg::ST_FETCH)
	`BDE_ASSERT_NEXT(a_refuse_hold, clk, arst_n, refused, $stable({count_q, head_q, tail_q}))

endmodule

/* dv/bounded_deque_engine_test.sv */
`timescale 1ns / 100ps

module bounded_deque_engine_test;

	localparam int unsigned RING_DEPTH = bde_pkg::DEPTH_DEFAULT;
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int RANDOM_ITEMS = 550;
	localparam int SCRIPT_ROWS = 13;

	typedef struct packed {
		logic [31:0] popped;
		logic [1:0]  status;
		logic [4:0]  count;
		logic        empty;
		logic [31:0] front;
		logic [31:0] back;
	} deque_result_t;

	typedef struct packed {
		logic [2:0]    op;
		logic [31:0]   word;
		logic [4:0]    reps;
		logic          typed;
		deque_result_t want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [2:0]         mode = bde_pkg::MODE_PEEK;
	logic signed [31:0] value_in = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic signed [31:0] value_out;
	logic [1:0]         status;
	logic [4:0]         entry_count;
	logic               is_empty;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;

	logic [31:0]   ring_words [RING_DEPTH];
	int unsigned   ring_head = 0;
	int unsigned   ring_held = 0;
	deque_result_t awaited_results [$];
	logic          req_typed = 1'b0;
	deque_result_t req_want = '0;
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;
	int            fail_count = 0;
	script_row_t   script [SCRIPT_ROWS];

	bounded_deque_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.value_in   (value_in),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.value_out  (value_out),
		.status     (status),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.front_value(front_value),
		.back_value (back_value)
	);

	always #6 clk = ~clk;

	function automatic int unsigned back_index();
		return (ring_head + ring_held + RING_DEPTH - 1) % RING_DEPTH;
	endfunction

	function automatic deque_result_t deque_apply(logic [2:0] op, logic [31:0] word);
		deque_result_t res;
		res = '0;
		res.status = bde_pkg::STAT_DONE;
		case (op)
			bde_pkg::MODE_PUSH_BACK: begin
				if (ring_held >= RING_DEPTH) begin
					res.status = bde_pkg::STAT_FULL;
				end else begin
					ring_held++;
					ring_words[back_index()] = word;
				end
			end
			bde_pkg::MODE_POP_FRONT: begin
				if (ring_held == 0) begin
					res.status = bde_pkg::STAT_EMPTY;
				end else begin
					res.popped = ring_words[ring_head];
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_held--;
				end
			end
			bde_pkg::MODE_PUSH_FRONT: begin
				if (ring_held >= RING_DEPTH) begin
					res.status = bde_pkg::STAT_FULL;
				end else begin
					ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
					ring_words[ring_head] = word;
					ring_held++;
				end
			end
			bde_pkg::MODE_POP_BACK: begin
				if (ring_held == 0) begin
					res.status = bde_pkg::STAT_EMPTY;
				end else begin
					res.popped = ring_words[back_index()];
					ring_held--;
				end
			end
			default: begin
			end
		endcase
		res.count = 5'(ring_held);
		res.empty = (ring_held == 0);
		if (ring_held != 0) begin
			res.front = ring_words[ring_head];
			res.back = ring_words[back_index()];
		end
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		deque_result_t want;
		deque_result_t predicted;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("value_out", want.popped, value_out);
					check_field("status", 32'(want.status), 32'(status));
					check_field("entry_count", 32'(want.count), 32'(entry_count));
					check_field("is_empty", 32'(want.empty), 32'(is_empty));
					check_field("front_value", want.front, front_value);
					check_field("back_value", want.back, back_value);
				end
			end
			if (req_valid && !req_stall) begin
				predicted = deque_apply(mode, value_in);
				awaited_results.push_back(req_typed ? req_want : predicted);
			end
		end
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_request(input logic [2:0] op, input logic [31:0] word,
			input logic typed, input deque_result_t want);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_typed = typed;
		req_want = want;
		req_valid <= 1'b1;
		mode <= op;
		value_in <= word;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// hold off new requests until every result has been transferred
	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [2:0] pick_mode(logic push_lean);
		int r;
		r = $urandom_range(99);
		if (r < 35) return push_lean ? bde_pkg::MODE_PUSH_BACK : bde_pkg::MODE_POP_FRONT;
		if (r < 70) return push_lean ? bde_pkg::MODE_PUSH_FRONT : bde_pkg::MODE_POP_BACK;
		if (r < 80) return push_lean ? bde_pkg::MODE_POP_FRONT : bde_pkg::MODE_PUSH_BACK;
		if (r < 90) return push_lean ? bde_pkg::MODE_POP_BACK : bde_pkg::MODE_PUSH_FRONT;
		if (r < 95) return bde_pkg::MODE_PEEK;
		return 3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO));
	endfunction

	function automatic logic [31:0] pick_word();
		if ($urandom_range(7) != 0) return $urandom;
		case ($urandom_range(3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	initial begin
		logic push_lean;
		int   lean_left;
		int   phase;
		int   row;
		int   n;
		int   per_phase;
		script = '{
			'{bde_pkg::MODE_POP_FRONT, 32'h0, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_EMPTY, 5'd0, 1'b1, 32'h0, 32'h0}},
			'{bde_pkg::MODE_POP_BACK, 32'h0, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_EMPTY, 5'd0, 1'b1, 32'h0, 32'h0}},
			'{bde_pkg::MODE_PEEK, 32'h1234, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_DONE, 5'd0, 1'b1, 32'h0, 32'h0}},
			'{bde_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_DONE, 5'd1, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff}},
			'{bde_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_DONE, 5'd2, 1'b0, 32'h8000_0000, 32'h7fff_ffff}},
			'{MODE_SPARE_LO, 32'hffff_ffff, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_DONE, 5'd2, 1'b0, 32'h8000_0000, 32'h7fff_ffff}},
			'{bde_pkg::MODE_POP_BACK, 32'h0, 5'd1, 1'b1,
				'{32'h7fff_ffff, bde_pkg::STAT_DONE, 5'd1, 1'b0, 32'h8000_0000,
					32'h8000_0000}},
			'{bde_pkg::MODE_POP_FRONT, 32'h0, 5'd1, 1'b1,
				'{32'h8000_0000, bde_pkg::STAT_DONE, 5'd0, 1'b1, 32'h0, 32'h0}},
			'{bde_pkg::MODE_PUSH_FRONT, 32'h0000_0100, 5'd8, 1'b0, '0},
			'{bde_pkg::MODE_PUSH_BACK, 32'hffff_ff00, 5'd8, 1'b0, '0},
			'{bde_pkg::MODE_PUSH_BACK, 32'h0, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_FULL, 5'd16, 1'b0, 32'h0000_0107, 32'hffff_ff07}},
			'{bde_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_FULL, 5'd16, 1'b0, 32'h0000_0107, 32'hffff_ff07}},
			'{bde_pkg::MODE_PEEK, 32'h0, 5'd1, 1'b1,
				'{32'h0, bde_pkg::STAT_DONE, 5'd16, 1'b0, 32'h0000_0107, 32'hffff_ff07}}
		};
		foreach (ring_words[i]) ring_words[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_gap_pct = 17;
		recv_stall_pct = 49;
		for (row = 0; row < SCRIPT_ROWS; row++) begin
			for (n = 0; n < script[row].reps; n++) begin
				send_request(script[row].op, script[row].word + 32'(n), script[row].typed,
					script[row].want);
			end
		end
		drain();

		push_lean = 1'b0;
		lean_left = 0;
		per_phase = RANDOM_ITEMS / 3;
		for (phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 17 : (phase == 1) ? 49 : 0;
			recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 17 : 0;
			for (n = 0; n < per_phase; n++) begin
				if (lean_left == 0) begin
					push_lean = ~push_lean;
					lean_left = $urandom_range(60, 20);
				end
				lean_left--;
				send_request(pick_mode(push_lean), pick_word(), 1'b0, '0);
				if (n == per_phase / 2) drain();
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
